// ===== sv/redb_pkg.sv =====
// Shared types and constants of the radial edge box-difference unit.
package redb_pkg;

	localparam int RADIUS_DEF         = 8;
	localparam int MAX_ROW_LENGTH_DEF = 4096;
	localparam int SAMPLE_BITS_DEF    = 16;

	localparam int SAMPLE_W    = 16;
	localparam int RESP_W      = 21;
	localparam int POS_W       = 12;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last_in_row;
	} in_beat_t;

	typedef struct packed {
		logic signed [RESP_W-1:0] response;
		logic [POS_W-1:0]         position;
		logic                     last_in_run;
		logic                     end_of_row;
	} out_beat_t;

	// One classified sample as handed from the front end to the back end.
	typedef struct packed {
		logic              has_main;
		logic              last;
		logic [POS_W-1:0]  pos_first;
		logic [POS_W-1:0]  pos_end;
		logic [RESP_W-1:0] ins;
		logic [RESP_W-1:0] outs;
	} job_t;

endpackage

// ===== sv/redb_in_if.sv =====
// Sample channel: valid/ready handshake carrying one input beat.
interface redb_in_if;
	logic               valid;
	logic               ready;
	redb_pkg::in_beat_t beat;

	modport source (output valid, output beat, input ready);
	modport sink (input valid, input beat, output ready);
endinterface

// ===== sv/redb_out_if.sv =====
// Result channel: valid/ready handshake carrying one result beat.
interface redb_out_if;
	logic                valid;
	logic                ready;
	redb_pkg::out_beat_t beat;

	modport source (output valid, output beat, input ready);
	modport sink (input valid, input beat, output ready);
endinterface

// ===== sv/radial_edge_box_difference_unit.sv =====
// Top level of the radial edge box-difference unit.
// Samples of a polar image arrive row by row on the samples channel, one beat per
// sample, the closing sample of each row flagged by last_in_row. For every position a
// of a row the unit returns the sum of the RADIUS samples before a minus the sum of the
// 2*RADIUS samples after a, and zero for a below RADIUS. Position a leaves once sample
// a+2*RADIUS has arrived; when a row closes, its remaining positions follow as zeros in
// one run, the last beat of that run marked end_of_row, and last_in_run marks the final
// result beat caused by each sample. A row reaching MAX_ROW_LENGTH samples closes on its
// own. Samples are accepted one per clock cycle while the queue has room. An ordinary
// sample yields at most one result beat, so the unit streams at one beat per cycle
// while the result channel keeps up; a closing sample yields up to 2*RADIUS+1 beats,
// which the back end emits one per cycle as the result channel takes them, and a
// four-entry queue between the front end and the back end buffers the jobs; the
// sample channel stalls while that queue is full. A sample's first result beat
// passes the queue, the back end's job register and its output register in turn.
module radial_edge_box_difference_unit #(
	parameter int RADIUS         = redb_pkg::RADIUS_DEF,
	parameter int MAX_ROW_LENGTH = redb_pkg::MAX_ROW_LENGTH_DEF,
	parameter int SAMPLE_BITS    = redb_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	redb_in_if.sink    samples,
	redb_out_if.source results
);

	// Classified samples travelling from the front end into the queue.
	logic           push_valid, push_ready;
	redb_pkg::job_t push_job;

	// Head of the queue as seen by the back end.
	logic           head_valid, head_pop;
	redb_pkg::job_t head_job;

	// The front end keeps the delay line and both running sums; a sample with results
	// becomes a job: an optional main response plus, at a row's end, a run of zeros.
	redb_front #(
		.RADIUS        (RADIUS),
		.MAX_ROW_LENGTH(MAX_ROW_LENGTH),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.push_valid(push_valid),
		.push_job  (push_job),
		.push_ready(push_ready)
	);

	// The queue lets the front end keep accepting samples while the back end drains a
	// row-end run or waits on a stalled result channel.
	redb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_job  (push_job),
		.push_ready(push_ready),
		.pop_valid (head_valid),
		.pop_job   (head_job),
		.pop       (head_pop)
	);

	// The back end forms the difference of the two sums and walks the positions of each
	// job through a registered output stage, one beat per cycle unless results stall.
	redb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(head_valid),
		.job      (head_job),
		.job_pop  (head_pop),
		.results  (results)
	);

endmodule

// ===== sv/redb_front.sv =====
// Front end: sample delay line, running window sums and row classification.
module redb_front #(
	parameter int RADIUS         = redb_pkg::RADIUS_DEF,
	parameter int MAX_ROW_LENGTH = redb_pkg::MAX_ROW_LENGTH_DEF,
	parameter int SAMPLE_BITS    = redb_pkg::SAMPLE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	redb_in_if.sink        samples,
	output logic           push_valid,
	output redb_pkg::job_t push_job,
	input  logic           push_ready
);

	localparam int SPAN  = 2 * RADIUS;
	localparam int LINE  = 3 * RADIUS;
	localparam int IDX_W = $clog2(MAX_ROW_LENGTH);
	localparam int EXT_W = IDX_W + redb_pkg::POS_W;
	localparam logic [redb_pkg::SAMPLE_W-1:0] S_MASK = (SAMPLE_BITS >= redb_pkg::SAMPLE_W) ?
		'1 : redb_pkg::SAMPLE_W'((1 << SAMPLE_BITS) - 1);

	logic [redb_pkg::SAMPLE_W-1:0] dl_q [LINE];
	logic [redb_pkg::RESP_W-1:0]   ins_q, outs_q;
	logic [IDX_W-1:0]              idx_q;

	logic [redb_pkg::SAMPLE_W-1:0] s;
	logic [redb_pkg::RESP_W-1:0]   ins_n, outs_n;
	logic                          accept, last, has_main, live;
	logic [EXT_W-1:0]              idx_ext, main_ext;

	always_comb begin
		s        = samples.beat.sample & S_MASK;
		// Window after position i-2R gains sample i and loses sample i-2R.
		outs_n   = outs_q + redb_pkg::RESP_W'(s) - redb_pkg::RESP_W'(dl_q[SPAN-1]);
		// The window before the next position gains sample i-2R and loses sample i-3R.
		ins_n    = ins_q + redb_pkg::RESP_W'(dl_q[SPAN-1]) - redb_pkg::RESP_W'(dl_q[LINE-1]);
		last     = samples.beat.last_in_row || (idx_q == IDX_W'(MAX_ROW_LENGTH - 1));
		has_main = idx_q >= IDX_W'(SPAN);
		live     = idx_q >= IDX_W'(LINE);
		idx_ext  = EXT_W'(idx_q);
		main_ext = EXT_W'(idx_q - IDX_W'(SPAN));
		accept   = samples.valid && push_ready;

		push_valid          = accept && (has_main || last);
		push_job.has_main   = has_main;
		push_job.last       = last;
		push_job.pos_first  = has_main ? main_ext[redb_pkg::POS_W-1:0] : '0;
		push_job.pos_end    = idx_ext[redb_pkg::POS_W-1:0];
		push_job.ins        = live ? ins_q : '0;
		push_job.outs       = live ? outs_n : '0;
	end

	assign samples.ready = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE; k++) dl_q[k] <= '0;
			ins_q  <= '0;
			outs_q <= '0;
			idx_q  <= '0;
		end else if (accept) begin
			if (last) begin
				for (int k = 0; k < LINE; k++) dl_q[k] <= '0;
				ins_q  <= '0;
				outs_q <= '0;
				idx_q  <= '0;
			end else begin
				for (int k = LINE - 1; k > 0; k--) dl_q[k] <= dl_q[k-1];
				dl_q[0] <= s;
				ins_q   <= ins_n;
				outs_q  <= outs_n;
				idx_q   <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

// ===== sv/redb_queue.sv =====
// Short register queue of classified samples between front and back end.
module redb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  redb_pkg::job_t push_job,
	output logic           push_ready,
	output logic           pop_valid,
	output redb_pkg::job_t pop_job,
	input  logic           pop
);

	localparam int PTR_W = $clog2(redb_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	redb_pkg::job_t   mem_q [redb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(redb_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PTR_W'(1);
			if (do_pop) rd_q <= rd_q + PTR_W'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

// ===== sv/redb_back.sv =====
// Back end: expands each classified sample into its run of result beats.
module redb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  redb_pkg::job_t job,
	output logic           job_pop,
	redb_out_if.source     results
);

	redb_pkg::job_t               job_q;
	logic                         act_q, main_q, ovld_q;
	logic [redb_pkg::POS_W-1:0]   pos_q;
	redb_pkg::out_beat_t          beat_q, item;
	logic                         fin, advance, load;

	always_comb begin
		// The main response is final unless the row closes; zeros end at the row's last index.
		fin              = main_q ? !job_q.last : (pos_q == job_q.pos_end);
		item.response    = main_q ? $signed(job_q.ins - job_q.outs) : '0;
		item.position    = pos_q;
		item.last_in_run = fin;
		item.end_of_row  = fin && job_q.last;
		advance          = act_q && (!ovld_q || results.ready);
		load             = job_valid && (!act_q || (advance && fin));
		job_pop          = load;
	end

	assign results.valid = ovld_q;
	assign results.beat  = beat_q;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
		if (advance) beat_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			main_q <= 1'b0;
			pos_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				act_q  <= 1'b1;
				main_q <= job.has_main;
				pos_q  <= job.pos_first;
			end else if (advance && fin) begin
				act_q <= 1'b0;
			end else if (advance) begin
				main_q <= 1'b0;
				pos_q  <= pos_q + redb_pkg::POS_W'(1);
			end
			if (advance) ovld_q <= 1'b1;
			else if (results.ready) ovld_q <= 1'b0;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the radial edge box-difference unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import redb_pkg::*;

	// Geometry of the window, taken from the package defaults the unit is built with.
	localparam int RAD      = RADIUS_DEF;
	localparam int SPAN     = 2 * RAD;
	localparam int LINE_LEN = 3 * RAD;

	// The receiver's long hold-off, in cycles, and the settling time allowed at the end.
	localparam int LONG_HOLD    = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 272;

	logic clk;
	logic arst_n;

	redb_in_if  samples_ch ();
	redb_out_if results_ch ();

	radial_edge_box_difference_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	// One row of the directed table. Where typed is set, the expected beats are written
	// out here: n_typed beats at consecutive positions from first_pos, the first one
	// carrying first_resp and the rest zero. Otherwise the predictor supplies them.
	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		bit                  last;
		bit                  typed;
		int                  n_typed;
		int                  first_pos;
		int                  first_resp;
	} stim_row_t;

	stim_row_t plan [28] = '{
		// A row of a single sample closes at once with one zero at position 0.
		'{16'hFFFF, 1'b1, 1'b1, 1, 0, 0},
		// A two-sample row: nothing until it closes, then two zeros.
		'{16'h8001, 1'b0, 1'b0, 0, 0, 0},
		'{16'h7FFE, 1'b1, 1'b0, 0, 0, 0},
		// A row of 25: eight full-scale samples, then zeros. The first 2*RADIUS samples
		// fill the window and give nothing; the next eight give the zero positions below
		// RADIUS; the closing sample gives the largest positive response at position 8
		// followed by the trailing zeros, seventeen beats in all.
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'hFFFF, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 0, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 0, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 1, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 2, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 3, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 4, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 5, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 6, 0},
		'{16'h0000, 1'b0, 1'b1, 1, 7, 0},
		'{16'h0000, 1'b1, 1'b1, 17, 8, 524280}
	};

	// Predictor state: the last 3*RADIUS samples of the row, newest first, and the
	// index of the next sample within its row.
	logic [SAMPLE_W-1:0] window_line [LINE_LEN];
	int                  col_idx;

	// Beats produced by the latest sample, and the beats still owed by the unit.
	out_beat_t step_results [$];
	out_beat_t expected_results [$];

	int fault_count;
	bit no_idle;
	bit hold_req;

	// Advances the predictor by one accepted sample and leaves the beats it causes in
	// step_results. The response at position a is the sum of the RADIUS samples before a
	// less the sum of the 2*RADIUS samples after it; the newest sample is a+2*RADIUS.
	function automatic void filter_step(input in_beat_t b);
		logic [SAMPLE_W-1:0] s;
		bit                  closing;
		int                  inner;
		int                  outer;
		int                  a;
		int                  k;
		out_beat_t           r;

		s = b.sample & SAMPLE_W'((64'd1 << SAMPLE_BITS_DEF) - 1);
		// A row that reaches its maximum length closes whatever the flag says.
		closing = b.last_in_row || (col_idx >= MAX_ROW_LENGTH_DEF - 1);
		step_results.delete();

		inner = 0;
		outer = int'(s);
		for (k = 0; k <= SPAN - 2; k++)
			outer += int'(window_line[k]);
		for (k = SPAN; k < LINE_LEN; k++)
			inner += int'(window_line[k]);

		if (col_idx >= SPAN) begin
			a = col_idx - SPAN;
			r = '0;
			r.position = POS_W'(a);
			if (a >= RAD)
				r.response = RESP_W'(inner - outer);
			step_results = {step_results, r};
		end

		// On closing, every position not yet given follows as a zero.
		if (closing) begin
			for (a = (col_idx >= SPAN) ? col_idx - SPAN + 1 : 0; a <= col_idx; a++) begin
				r = '0;
				r.position = POS_W'(a);
				step_results = {step_results, r};
			end
		end

		if (step_results.size() > 0) begin
			r = step_results.pop_back();
			r.last_in_run = 1'b1;
			r.end_of_row  = closing;
			step_results = {step_results, r};
		end

		if (closing) begin
			for (k = 0; k < LINE_LEN; k++)
				window_line[k] = '0;
			col_idx = 0;
		end else begin
			for (k = LINE_LEN - 1; k > 0; k--)
				window_line[k] = window_line[k-1];
			window_line[0] = s;
			col_idx++;
		end
	endfunction

	// Idle length for either side: mostly none, sometimes a few cycles, now and then long.
	function automatic int pick_gap();
		int roll;

		roll = $urandom_range(0, 99);
		if (no_idle || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 24);
	endfunction

	// Offers one sample beat on a falling edge after a random gap and returns at the
	// rising edge at which it is taken. The predictor is stepped there; with use_model
	// set its beats become the expectation, otherwise the caller supplies them.
	task automatic send_sample(input in_beat_t b, input bit use_model);
		int gap;

		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			samples_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid = 1'b1;
		samples_ch.beat  = b;
		do @(posedge clk); while (!samples_ch.ready);
		filter_step(b);
		if (use_model)
			expected_results = {expected_results, step_results};
	endtask

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Result side: every accepted beat is checked against the oldest expectation, and
	// ready is driven on the falling edge with random stalls, or the long hold-off when
	// the stimulus asks for one.
	initial begin : result_side
		int        stall;
		bit        took;
		out_beat_t got;
		out_beat_t want;

		results_ch.ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			took = results_ch.valid && results_ch.ready;
			if (took) begin
				got = results_ch.beat;
				if (expected_results.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result beat: response %0d position %0d last_in_run %0b end_of_row %0b",
							got.response, got.position, got.last_in_run, got.end_of_row);
				end else begin
					want = expected_results.pop_front();
					if (got.response !== want.response || got.position !== want.position ||
						got.last_in_run !== want.last_in_run ||
						got.end_of_row !== want.end_of_row) begin
						fault_count++;
						if (fault_count <= 10)
							$display("result mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
								want.response, want.position, want.last_in_run, want.end_of_row,
								got.response, got.position, got.last_in_run, got.end_of_row);
					end
				end
			end
			@(negedge clk);
			if (hold_req) begin
				stall    = LONG_HOLD;
				hold_req = 1'b0;
			end else if (took && stall == 0) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				results_ch.ready = 1'b0;
				stall--;
			end else begin
				results_ch.ready = 1'b1;
			end
		end
	end

	initial begin : stimulus
		in_beat_t            b;
		out_beat_t           r;
		int                  k;
		int                  j;
		int                  width;
		int                  kind;
		int                  style;
		int                  row_no;
		int                  random_items;
		bit                  noise;
		logic [SAMPLE_W-1:0] level;

		samples_ch.valid = 1'b0;
		samples_ch.beat  = '0;
		fault_count      = 0;
		no_idle          = 1'b0;
		hold_req         = 1'b0;
		col_idx          = 0;
		for (k = 0; k < LINE_LEN; k++)
			window_line[k] = '0;
		@(posedge arst_n);

		// Directed table.
		foreach (plan[k]) begin
			b.sample      = plan[k].sample;
			b.last_in_row = plan[k].last;
			send_sample(b, !plan[k].typed);
			if (plan[k].typed) begin
				for (j = 0; j < plan[k].n_typed; j++) begin
					r = '0;
					r.position    = POS_W'(plan[k].first_pos + j);
					r.last_in_run = (j == plan[k].n_typed - 1);
					r.end_of_row  = plan[k].last && (j == plan[k].n_typed - 1);
					if (j == 0)
						r.response = RESP_W'(plan[k].first_resp);
					expected_results = {expected_results, r};
				end
			end
		end

		// Random rows. Most are well formed with random content; some sit on the
		// 2*RADIUS boundary of width, some are wider, and some carry the row flag at
		// random so that rows break off early or run on into the next.
		row_no       = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			kind    = $urandom_range(0, 9);
			if (kind == 0)
				width = SPAN - 1 + $urandom_range(0, 3);
			else if (kind < 7)
				width = $urandom_range(1, 40);
			else
				width = $urandom_range(41, 120);
			noise = (kind == 9);

			if (row_no == 1) begin
				// The result side holds off for a long stretch while samples keep coming,
				// so the queue fills and the sample channel must stall.
				hold_req = 1'b1;
				no_idle  = 1'b1;
				width    = 60;
				noise    = 1'b0;
			end else if (row_no == 3) begin
				// The sender pauses until every owed beat has come back.
				@(negedge clk);
				samples_ch.valid = 1'b0;
				while (expected_results.size() != 0) @(negedge clk);
			end

			// The last row is cut short so that the run keeps to its sample budget.
			if (width > RANDOM_ITEMS - random_items)
				width = RANDOM_ITEMS - random_items;

			style = $urandom_range(0, 2);
			level = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			for (j = 0; j < width; j++) begin
				case (style)
					0: b.sample = SAMPLE_W'($urandom);
					// Runs of black and full white reach the extreme responses.
					1: begin
						if ($urandom_range(0, 7) == 0)
							level = ~level;
						b.sample = level;
					end
					default: b.sample = SAMPLE_W'($urandom_range(0, 255));
				endcase
				b.last_in_row = noise ? ($urandom_range(0, 5) == 0) : (j == width - 1);
				send_sample(b, 1'b1);
				random_items++;
			end
			row_no++;
		end

		@(negedge clk);
		samples_ch.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hang: the slowest correct run needs a small fraction of this.
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== radial_edge_box_difference_unit.f =====
sv/redb_pkg.sv
sv/redb_in_if.sv
sv/redb_out_if.sv
sv/redb_front.sv
sv/redb_queue.sv
sv/redb_back.sv
sv/radial_edge_box_difference_unit.sv
tb/testbench.sv
